[sv/b64d_pkg.sv]
// shared types, codes and character classification for the base64 stream decoder
package b64d_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // classifier codes beyond the sextet range
  localparam logic [6:0] SEXT_PAD = 7'd64;
  localparam logic [6:0] SEXT_BAD = 7'd65;

  // characters of interest
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // decoded request queue depth (power of two)
  localparam int QDEPTH = 4;
  localparam int QPTW   = $clog2(QDEPTH);

  // input request
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } b64d_in_t;

  // one result
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       out_last;
  } b64d_out_t;

  // work handed from front to back: up to three bytes then an optional end result
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  ndata;
    logic        has_end;
    logic [1:0]  end_kind;
  } b64d_cmd_t;

  // sextet value 0..63, SEXT_PAD for '=', SEXT_BAD for anything else
  function automatic logic [6:0] b64d_classify(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'd65;
      return t[6:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'd71;
      return t[6:0];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'd4;
      return t[6:0];
    end else if (c == CH_PLUS) begin
      return 7'd62;
    end else if (c == CH_SLASH) begin
      return 7'd63;
    end else if (c == CH_EQ) begin
      return SEXT_PAD;
    end
    return SEXT_BAD;
  endfunction

endpackage

[sv/b64d_front.sv]
// front end: accepts characters, gathers quads and issues decoded work
module b64d_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  b64d_pkg::b64d_in_t  in_data,
  output logic                cmd_push,
  output b64d_pkg::b64d_cmd_t cmd
);
  import b64d_pkg::*;

  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  chars_r, chars_nxt;
  logic [2:0]  pads_r, pads_nxt;
  logic        discard_r, discard_nxt;

  // quad gathering and result decision
  always_comb begin
    logic       ws;
    logic       err;
    logic       last;
    logic [6:0] s;
    logic [5:0] sx;
    logic [2:0] pads_n;
    logic [2:0] ndata3;
    ws          = (in_data.in_char == CH_LF) || (in_data.in_char == CH_CR) ||
                  (in_data.in_char == CH_SP) || (in_data.in_char == CH_TAB);
    last        = in_data.in_last;
    err         = 1'b0;
    s           = b64d_classify(in_data.in_char);
    sx          = (s == SEXT_PAD) ? 6'd0 : s[5:0];
    pads_n      = pads_r + ((s == SEXT_PAD) ? 3'd1 : 3'd0);
    ndata3      = 3'd3 - pads_n;
    acc_nxt     = acc_r;
    chars_nxt   = chars_r;
    pads_nxt    = pads_r;
    discard_nxt = discard_r;
    cmd         = '0;
    cmd_push    = 1'b0;
    if (in_fire) begin
      if (discard_r) begin
        if (last) begin
          discard_nxt = 1'b0;
        end
      end else begin
        if (!(chars_r == 2'd0 && ws)) begin
          if (s == SEXT_BAD) begin
            err = 1'b1;
          end else if (chars_r != 2'd3) begin
            acc_nxt   = {acc_r[11:0], sx};
            chars_nxt = chars_r + 2'd1;
            pads_nxt  = pads_n;
          end else begin
            // quad complete
            if (pads_n >= 3'd3) begin
              err = 1'b1;
            end else begin
              cmd.data  = {acc_r, sx};
              cmd.ndata = ndata3[1:0];
            end
            acc_nxt   = '0;
            chars_nxt = 2'd0;
            pads_nxt  = 3'd0;
          end
        end
        if (err) begin
          cmd.has_end  = 1'b1;
          cmd.end_kind = KIND_ERR;
          acc_nxt      = '0;
          chars_nxt    = 2'd0;
          pads_nxt     = 3'd0;
          discard_nxt  = !last;
        end else if (last) begin
          cmd.has_end  = 1'b1;
          cmd.end_kind = (chars_nxt != 2'd0) ? KIND_ERR : KIND_OK;
          acc_nxt      = '0;
          chars_nxt    = 2'd0;
          pads_nxt     = 3'd0;
        end
        cmd_push = (cmd.ndata != 2'd0) || cmd.has_end;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      chars_r   <= '0;
      pads_r    <= '0;
      discard_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      chars_r   <= chars_nxt;
      pads_r    <= pads_nxt;
      discard_r <= discard_nxt;
    end
  end

  // while discarding no quad is open
  assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> (chars_r == 2'd0 && pads_r == 3'd0 && acc_r == '0))
    else $error("quad state left open while discarding");

endmodule

[sv/b64d_queue.sv]
// short queue of decoded work between front and back
module b64d_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64d_pkg::b64d_cmd_t push_cmd,
  input  logic                pop,
  output b64d_pkg::b64d_cmd_t head,
  output logic                empty,
  output logic                full
);
  import b64d_pkg::*;

  b64d_cmd_t         mem_r [QDEPTH];
  logic [QPTW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTW:0]     count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (QPTW+1)'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count update, pointers wrap at the power-of-two depth
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTW+1)'(push) - (QPTW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // fill count tracks the pointer distance
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= (QPTW+1)'(QDEPTH)) &&
    (wr_ptr_r == rd_ptr_r + count_r[QPTW-1:0]))
    else $error("queue count and pointers disagree");

endmodule

[sv/b64d_back.sv]
// back end: queued work to results, one per cycle unless stalled, via output register
module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  b64d_pkg::b64d_cmd_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::b64d_out_t out_data
);
  import b64d_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  b64d_out_t  out_data_r, res;
  logic [2:0] cnt;
  logic       last_res;
  logic       load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pick the result at the current position of the head entry
  always_comb begin
    cnt      = {1'b0, head.ndata} + {2'b00, head.has_end};
    last_res = ({1'b0, idx_r} == cnt - 3'd1);
    res      = '0;
    if (idx_r < head.ndata) begin
      res.out_kind = KIND_DATA;
      unique case (idx_r)
        2'd0:    res.out_byte = head.data[23:16];
        2'd1:    res.out_byte = head.data[15:8];
        default: res.out_byte = head.data[7:0];
      endcase
    end else begin
      res.out_kind = head.end_kind;
    end
    res.out_last = last_res;
  end

  assign load = !empty && (!out_valid_r || out_ready);
  assign pop  = load && last_res;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = last_res ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  // position never runs past the head entry's result count
  assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ({1'b0, idx_r} < cnt))
    else $error("result position beyond entry");

  // non-data results carry a zero byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_kind != KIND_DATA) |-> (out_data_r.out_byte == 8'd0))
    else $error("end result with non-zero byte");

endmodule

[sv/base64_stream_decoder_unit.sv]
// top level of the base64 stream decoder: front end, work queue and back end
//
//  channel | ports                         | moves
//  --------+-------------------------------+-----------------------------------
//  input   | in_valid, in_ready, in_data   | one character and its last flag
//  output  | out_valid, out_ready, out_data| one byte, its kind and last flag
//
// A character is taken every cycle while the four-entry work queue has room.
// Results leave at one per cycle from the output register while out_ready is high;
// a quad of four characters gives at most four results, so the back end keeps pace
// on average. Reset (rst_n low at a clock edge) empties the queue, closes any quad
// and clears discarding. A stalled output fills the queue before in_ready drops.
module base64_stream_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64d_pkg::b64d_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::b64d_out_t out_data
);
  import b64d_pkg::*;

  b64d_cmd_t cmd, head;
  logic      cmd_push, pop, empty, full, in_fire;

  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[test/base64_stream_decoder_unit_tb.sv]
// testbench for the base64 stream decoder: random and directed requests checked by a predictor
`timescale 1ns / 1ps

module base64_stream_decoder_unit_tb;
  import b64d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 370;
  localparam int DRAIN_CYCLES = 20;

  // one queued request and whether the sender waits for an empty pipe before it
  typedef struct {
    b64d_in_t req;
    bit       hold;
  } char_req_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  b64d_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  b64d_out_t out_data;

  char_req_t  char_q[$];
  logic [7:0] msg_buf[$];
  b64d_out_t  decoded_q[$];

  // predictor state
  logic [17:0] quad_bits;
  logic [1:0]  quad_chars;
  logic [2:0]  quad_pads;
  bit          dropping;

  int        mismatch_cnt;
  int        cycle_cnt;
  int        sent;
  int        idle_pct;
  int        stall_pct;
  bit        in_fire;
  char_req_t next_req;

  base64_stream_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // 6-bit value of a character, or the pad / invalid codes
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= "A" && c <= "Z") v = c - "A";
    else if (c >= "a" && c <= "z") v = c - "a" + 8'd26;
    else if (c >= "0" && c <= "9") v = c - "0" + 8'd52;
    else if (c == CH_PLUS) v = 8'd62;
    else if (c == CH_SLASH) v = 8'd63;
    else if (c == CH_EQ) return SEXT_PAD;
    else return SEXT_BAD;
    return v[6:0];
  endfunction

  // character that encodes a 6-bit value
  function automatic logic [7:0] b64_char(input int v);
    if (v < 26) return 8'(v) + "A";
    if (v < 52) return 8'(v - 26) + "a";
    if (v < 62) return 8'(v - 52) + "0";
    if (v == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(3))
      0: return CH_LF;
      1: return CH_CR;
      2: return CH_SP;
      default: return CH_TAB;
    endcase
  endfunction

  // work out the results of one accepted request and queue them
  task automatic decode_char(input b64d_in_t r);
    b64d_out_t   res[4];
    logic [6:0]  sx;
    logic [23:0] word;
    bit          err;
    int          n;
    n = 0;
    err = 0;
    if (dropping) begin
      if (r.in_last) dropping = 0;
    end else begin
      // whitespace only passes between quads
      if (!(quad_chars == 2'd0 && (r.in_char == CH_LF || r.in_char == CH_CR ||
                                   r.in_char == CH_SP || r.in_char == CH_TAB))) begin
        sx = sextet_of(r.in_char);
        if (sx == SEXT_BAD) begin
          err = 1;
        end else begin
          if (sx == SEXT_PAD) begin
            sx = 7'd0;
            quad_pads = quad_pads + 3'd1;
          end
          if (quad_chars != 2'd3) begin
            quad_bits = {quad_bits[11:0], sx[5:0]};
            quad_chars = quad_chars + 2'd1;
          end else begin
            // quad complete: emit bytes unless too many pads
            word = {quad_bits, sx[5:0]};
            if (quad_pads >= 3'd3) begin
              err = 1;
            end else begin
              for (int i = 0; i < 3 - int'(quad_pads); i++) begin
                res[n].out_byte = word[23 - 8 * i -: 8];
                res[n].out_kind = KIND_DATA;
                res[n].out_last = 1'b0;
                n = n + 1;
              end
            end
            quad_bits = '0;
            quad_chars = '0;
            quad_pads = '0;
          end
        end
      end
      // error or end of message
      if (err || r.in_last) begin
        res[n].out_byte = 8'd0;
        res[n].out_kind = (err || quad_chars != 2'd0) ? KIND_ERR : KIND_OK;
        res[n].out_last = 1'b0;
        n = n + 1;
        quad_bits = '0;
        quad_chars = '0;
        quad_pads = '0;
        dropping = err && !r.in_last;
      end
      for (int i = 0; i < n; i++) begin
        res[i].out_last = (i == n - 1);
        decoded_q.push_back(res[i]);
      end
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("cycle %0d: %s", cycle_cnt, what);
    mismatch_cnt = mismatch_cnt + 1;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
  endtask

  // move the message under construction into the request queue
  task automatic post_message(input bit hold_first);
    char_req_t e;
    for (int i = 0; i < msg_buf.size(); i++) begin
      e.req.in_char = msg_buf[i];
      e.req.in_last = (i == msg_buf.size() - 1);
      e.hold = hold_first && (i == 0);
      char_q.push_back(e);
    end
    msg_buf.delete();
  endtask

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // monitor: check results, then predict from the accepted request
  always @(posedge clk) begin
    b64d_out_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result byte %h kind %0d last %0b",
                                  out_data.out_byte, out_data.out_kind, out_data.out_last));
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %h, expected %h",
                                    out_data.out_byte, want.out_byte));
          if (out_data.out_kind !== want.out_kind)
            flag_mismatch($sformatf("out_kind %0d, expected %0d",
                                    out_data.out_kind, want.out_kind));
          if (out_data.out_last !== want.out_last)
            flag_mismatch($sformatf("out_last %0b, expected %0b",
                                    out_data.out_last, want.out_last));
        end
      end
      if (in_valid && in_ready) decode_char(in_data);
      in_fire <= in_valid && in_ready;
    end
  end

  // driver: idle and stall pattern changes every 45 requests
  always @(negedge clk) begin
    if (rst_n) begin
      case ((sent / 45) % 5)
        1: begin idle_pct = 83; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 83; end
        3: begin idle_pct = 38; stall_pct = 38; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (!in_valid || in_fire) begin
        if (char_q.size() != 0 && (!char_q[0].hold || decoded_q.size() == 0) &&
            $urandom_range(99) >= idle_pct) begin
          next_req = char_q.pop_front();
          in_data <= next_req.req;
          in_valid <= 1'b1;
          sent <= sent + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // stimulus, reset and end of run
  initial begin
    int nq;
    int npad;
    int base;
    int pick;
    bit tail;
    bit first_rand;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    quad_bits = '0;
    quad_chars = '0;
    quad_pads = '0;
    dropping = 0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    first_rand = 1;

    // letter and digit extremes, whitespace between quads, pads apart, clean end
    msg_buf.push_back(CH_LF);
    put_text("AZaz");
    msg_buf.push_back(CH_CR);
    msg_buf.push_back(CH_TAB);
    put_text("09+/=Q=Q");
    post_message(0);
    // zero byte inside a quad on the last character
    msg_buf.push_back("Q");
    msg_buf.push_back(8'h00);
    post_message(0);
    // invalid top-bit character alone
    msg_buf.push_back(8'hFF);
    post_message(0);
    // whitespace inside a quad
    put_text("A ");
    post_message(0);
    // four pads mid-message, then the rest is dropped up to the last character
    put_text("====AB");
    post_message(0);
    // three pads on the last character
    put_text("Q===");
    post_message(0);
    // unfinished quad at the end
    put_text("QU");
    post_message(0);

    // random messages, mostly well formed
    while (char_q.size() < ITEM_TARGET) begin
      nq = $urandom_range(4);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(3) == 0) msg_buf.push_back(space_char());
        base = msg_buf.size();
        for (int k = 0; k < 4; k++) msg_buf.push_back(b64_char($urandom_range(63)));
        npad = 0;
        if (q == nq - 1 || $urandom_range(7) == 0) begin
          pick = $urandom_range(15);
          npad = (pick < 6) ? 0 : (pick < 10) ? 1 : (pick < 14) ? 2 : (pick == 14) ? 3 : 4;
        end
        tail = ($urandom_range(3) != 0);
        for (int p = 0; p < npad; p++)
          msg_buf[base + (tail ? 3 - p : $urandom_range(3))] = CH_EQ;
      end
      if (nq == 0 || $urandom_range(4) == 0) msg_buf.push_back(space_char());
      // broken messages: stray byte, truncation or whitespace inserted at a random place
      if ($urandom_range(99) < 20) begin
        case ($urandom_range(2))
          0: msg_buf[$urandom_range(msg_buf.size() - 1)] = 8'($urandom_range(255));
          1: if (msg_buf.size() > 1) void'(msg_buf.pop_back());
          default: msg_buf.insert($urandom_range(msg_buf.size() - 1), space_char());
        endcase
      end
      post_message(first_rand || $urandom_range(19) == 0);
      first_rand = 0;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_q.size() != 0 || in_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder_unit.sv
test/base64_stream_decoder_unit_tb.sv
